// ===== sv/midpoint_line_rasterizer_assert.svh =====
// Assertion macros used by the rasterizer port checker
`ifndef MIDPOINT_LINE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define MLR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("midpoint_line_rasterizer: same-cycle check failed");

// next-cycle implication
`define MLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("midpoint_line_rasterizer: next-cycle check failed");

`endif

// ===== sv/mlr_pkg.sv =====
// Types and constants of the midpoint line rasterizer
package mlr_pkg;

   localparam int COORD_BITS = 12;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int DEC_BITS   = COORD_BITS + 3;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic ST_OK      = 1'b0;
   localparam logic ST_NO_LINE = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic        [DELTA_BITS-1:0] mag_type;
   typedef logic signed [DEC_BITS-1:0]   dec_type;

   typedef struct packed {
      logic      opcode;
      coord_type first_x;
      coord_type first_y;
      coord_type second_x;
      coord_type second_y;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last_pixel;
      logic      status;
   } rsp_type;

endpackage

// ===== sv/mlr_if.sv =====
// Valid/ready channels for rasterizer requests and pixels
interface mlr_req_if;
   logic              valid;
   logic              ready;
   mlr_pkg::req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mlr_rsp_if;
   logic              valid;
   logic              ready;
   mlr_pkg::rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/midpoint_line_rasterizer.sv =====
// An accepted item waits in the input register; its pixel is loaded from there into
// the result register, shown on rsp_ch until taken. Throughput: one item per cycle
// unless rsp_ch stalls; the decision add/compare and coordinate step fit between
// the input and result registers, so the line state updates every cycle.
// req_ch.ready drops only while both registers are full and the result is stalled.
// Synchronous active-high reset empties both registers and clears the active line.
module midpoint_line_rasterizer (
   input  logic            clock,
   input  logic            reset,
   mlr_req_if.sink         req_ch,
   mlr_rsp_if.source       rsp_ch
);

   logic                in_valid_ff;
   mlr_pkg::req_type    in_data_ff;
   logic                out_valid_ff;
   mlr_pkg::rsp_type    out_data_ff;
   mlr_pkg::rsp_type    out_data_in;

   mlr_pkg::coord_type  cur_x_ff, cur_x_in;
   mlr_pkg::coord_type  cur_y_ff, cur_y_in;
   mlr_pkg::coord_type  end_major_ff, end_major_in;
   mlr_pkg::dec_type    decision_ff, decision_in;
   mlr_pkg::dec_type    incr_straight_ff, incr_straight_in;
   mlr_pkg::dec_type    incr_diag_ff, incr_diag_in;
   logic                steep_ff, steep_in;
   logic                neg_ff, neg_in;
   logic                active_ff, active_in;

   logic                move;

   // start-item setup
   mlr_pkg::delta_type  dx, dy;
   mlr_pkg::mag_type    adx, ady, mag_a, mag_b;
   mlr_pkg::dec_type    a_ext, b_ext, two_b, two_amb;
   logic                s_steep, s_neg, x_first, y_first;
   mlr_pkg::coord_type  s_x, s_y, s_end;

   // step
   logic                diag;
   mlr_pkg::coord_type  t_x, t_y;
   mlr_pkg::dec_type    t_dec;

   mlr_pkg::coord_type  major;
   logic                last;

   assign move         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || move;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

   always_comb begin
      dx  = mlr_pkg::delta_type'(in_data_ff.second_x) - mlr_pkg::delta_type'(in_data_ff.first_x);
      dy  = mlr_pkg::delta_type'(in_data_ff.second_y) - mlr_pkg::delta_type'(in_data_ff.first_y);
      adx = dx[mlr_pkg::DELTA_BITS-1] ? mlr_pkg::mag_type'(-dx) : mlr_pkg::mag_type'(dx);
      ady = dy[mlr_pkg::DELTA_BITS-1] ? mlr_pkg::mag_type'(-dy) : mlr_pkg::mag_type'(dy);
      s_steep = ady > adx;
      s_neg   = (dx != '0) && (dy != '0)
                && (dx[mlr_pkg::DELTA_BITS-1] != dy[mlr_pkg::DELTA_BITS-1]);
      x_first = in_data_ff.first_x <= in_data_ff.second_x;
      y_first = in_data_ff.first_y <= in_data_ff.second_y;
      if (!s_steep) begin
         mag_a = adx;
         mag_b = ady;
         s_x   = x_first ? in_data_ff.first_x  : in_data_ff.second_x;
         s_y   = x_first ? in_data_ff.first_y  : in_data_ff.second_y;
         s_end = x_first ? in_data_ff.second_x : in_data_ff.first_x;
      end else begin
         mag_a = ady;
         mag_b = adx;
         s_y   = y_first ? in_data_ff.first_y  : in_data_ff.second_y;
         s_x   = y_first ? in_data_ff.first_x  : in_data_ff.second_x;
         s_end = y_first ? in_data_ff.second_y : in_data_ff.first_y;
      end
      a_ext   = mlr_pkg::dec_type'({2'b00, mag_a});
      b_ext   = mlr_pkg::dec_type'({2'b00, mag_b});
      two_b   = b_ext <<< 1;
      two_amb = (a_ext - b_ext) <<< 1;
   end

   always_comb begin
      diag  = neg_ff ? (decision_ff > 0) : (decision_ff <= 0);
      t_dec = decision_ff + (diag ? incr_diag_ff : incr_straight_ff);
      t_x   = cur_x_ff;
      t_y   = cur_y_ff;
      if (!steep_ff) begin
         t_x = cur_x_ff + mlr_pkg::coord_type'(1);
         if (diag) begin
            t_y = neg_ff ? cur_y_ff - mlr_pkg::coord_type'(1)
                         : cur_y_ff + mlr_pkg::coord_type'(1);
         end
      end else begin
         t_y = cur_y_ff + mlr_pkg::coord_type'(1);
         if (diag) begin
            t_x = neg_ff ? cur_x_ff - mlr_pkg::coord_type'(1)
                         : cur_x_ff + mlr_pkg::coord_type'(1);
         end
      end
   end

   always_comb begin
      cur_x_in         = cur_x_ff;
      cur_y_in         = cur_y_ff;
      end_major_in     = end_major_ff;
      decision_in      = decision_ff;
      incr_straight_in = incr_straight_ff;
      incr_diag_in     = incr_diag_ff;
      steep_in         = steep_ff;
      neg_in           = neg_ff;
      active_in        = active_ff;

      if (in_data_ff.opcode == mlr_pkg::OP_START) begin
         cur_x_in     = s_x;
         cur_y_in     = s_y;
         end_major_in = s_end;
         steep_in     = s_steep;
         neg_in       = s_neg;
         if (!s_neg) begin
            decision_in      = a_ext - two_b;
            incr_straight_in = -two_b;
            incr_diag_in     = two_amb;
         end else begin
            decision_in      = two_b - a_ext;
            incr_straight_in = two_b;
            incr_diag_in     = -two_amb;
         end
      end else if (active_ff) begin
         cur_x_in    = t_x;
         cur_y_in    = t_y;
         decision_in = t_dec;
      end

      major = steep_in ? cur_y_in : cur_x_in;
      last  = major >= end_major_in;

      if (in_data_ff.opcode == mlr_pkg::OP_STEP && !active_ff) begin
         out_data_in.pixel_x    = '0;
         out_data_in.pixel_y    = '0;
         out_data_in.last_pixel = 1'b0;
         out_data_in.status     = mlr_pkg::ST_NO_LINE;
      end else begin
         out_data_in.pixel_x    = cur_x_in;
         out_data_in.pixel_y    = cur_y_in;
         out_data_in.last_pixel = last;
         out_data_in.status     = mlr_pkg::ST_OK;
         active_in              = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
            active_ff    <= active_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_data_ff <= req_ch.payload;
      end
      if (move) begin
         out_data_ff      <= out_data_in;
         cur_x_ff         <= cur_x_in;
         cur_y_ff         <= cur_y_in;
         end_major_ff     <= end_major_in;
         decision_ff      <= decision_in;
         incr_straight_ff <= incr_straight_in;
         incr_diag_ff     <= incr_diag_in;
         steep_ff         <= steep_in;
         neg_ff           <= neg_in;
      end
   end

endmodule

// ===== sv/mlr_checker.sv =====
// Port-level checks for the midpoint line rasterizer, bound to the top level
`include "midpoint_line_rasterizer_assert.svh"

module mlr_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  mlr_pkg::rsp_type  rsp_payload
);

   // a held pixel keeps its value until taken
   `MLR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // with the result register empty nothing can block the input
   `MLR_ASSERT_NOW(a_ready_when_drained, clock, reset, !rsp_valid, req_ready)

   // a no-line reply carries zero fields and no last flag
   `MLR_ASSERT_NOW(a_no_line_fields, clock, reset, rsp_valid && (rsp_payload.status == mlr_pkg::ST_NO_LINE), (rsp_payload.pixel_x == '0) && (rsp_payload.pixel_y == '0) && !rsp_payload.last_pixel)

   // nothing is shown right after reset
   `MLR_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset) && !req_valid, !rsp_valid)

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

// ===== test/mlr_pixel_checker.sv =====
// Pixel checker for the midpoint line rasterizer: predicts each pixel and compares
module mlr_pixel_checker (
   input  logic clock,
   input  logic reset,
   mlr_req_if   req_mon,
   mlr_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   import mlr_pkg::*;

   // line state
   coord_type pos_x;
   coord_type pos_y;
   coord_type major_end;
   dec_type   err_term;
   dec_type   err_straight;
   dec_type   err_diag;
   logic      y_major;
   logic      falling;
   logic      drawing;

   rsp_type   pixel_q[$];
   int        errors = 0;

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic rsp_type current_pixel();
      rsp_type   px;
      coord_type major;
      major         = y_major ? pos_y : pos_x;
      px.pixel_x    = pos_x;
      px.pixel_y    = pos_y;
      px.last_pixel = (major >= major_end);
      px.status     = ST_OK;
      if (px.last_pixel) drawing = 1'b0;
      return px;
   endfunction

   function automatic rsp_type rasterize(input req_type item);
      int      dx;
      int      dy;
      int      a;
      int      b;
      logic    diag;
      rsp_type px;
      if (item.opcode == OP_START) begin
         dx      = int'(item.second_x) - int'(item.first_x);
         dy      = int'(item.second_y) - int'(item.first_y);
         y_major = magnitude(dy) > magnitude(dx);
         falling = (dx != 0) && (dy != 0) && ((dx < 0) != (dy < 0));
         if (!y_major) begin
            a         = magnitude(dx);
            b         = magnitude(dy);
            pos_x     = (item.first_x < item.second_x) ? item.first_x : item.second_x;
            pos_y     = (pos_x == item.first_x) ? item.first_y : item.second_y;
            major_end = (item.first_x > item.second_x) ? item.first_x : item.second_x;
         end else begin
            a         = magnitude(dy);
            b         = magnitude(dx);
            pos_y     = (item.first_y < item.second_y) ? item.first_y : item.second_y;
            pos_x     = (pos_y == item.first_y) ? item.first_x : item.second_x;
            major_end = (item.first_y > item.second_y) ? item.first_y : item.second_y;
         end
         if (!falling) begin
            err_term     = dec_type'(a - 2 * b);
            err_straight = dec_type'(-2 * b);
            err_diag     = dec_type'(2 * (a - b));
         end else begin
            err_term     = dec_type'(2 * b - a);
            err_straight = dec_type'(2 * b);
            err_diag     = dec_type'(-2 * (a - b));
         end
         drawing = 1'b1;
         return current_pixel();
      end
      if (!drawing) begin
         px        = '0;
         px.status = ST_NO_LINE;
         return px;
      end
      diag     = falling ? (err_term > 0) : (err_term <= 0);
      err_term = err_term + (diag ? err_diag : err_straight);
      if (!y_major) begin
         if (diag) pos_y = falling ? pos_y - 1 : pos_y + 1;
         pos_x = pos_x + 1;
      end else begin
         if (diag) pos_x = falling ? pos_x - 1 : pos_x + 1;
         pos_y = pos_y + 1;
      end
      return current_pixel();
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      if (reset) begin
         pos_x        = '0;
         pos_y        = '0;
         major_end    = '0;
         err_term     = '0;
         err_straight = '0;
         err_diag     = '0;
         y_major      = 1'b0;
         falling      = 1'b0;
         drawing      = 1'b0;
         pixel_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (pixel_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected pixel: x=%0d y=%0d last=%0b status=%0b",
                           got.pixel_x, got.pixel_y, got.last_pixel, got.status);
            end else begin
               want = pixel_q.pop_front();
               if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                   got.last_pixel !== want.last_pixel || got.status !== want.status) begin
                  errors++;
                  if (errors <= 10)
                     $display("pixel mismatch: want x=%0d y=%0d last=%0b status=%0b, got x=%0d y=%0d last=%0b status=%0b",
                              want.pixel_x, want.pixel_y, want.last_pixel, want.status,
                              got.pixel_x, got.pixel_y, got.last_pixel, got.status);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) pixel_q.push_back(rasterize(req_mon.payload));
      end
      fail_count <= errors;
      pending    <= pixel_q.size();
   end

endmodule

// ===== test/tb.sv =====
// Testbench top for the midpoint line rasterizer: clock, reset, line stimulus, verdict
module tb;

   localparam int ITEM_TARGET = 1550;
   localparam int CYCLE_LIMIT = 250000;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset;
   logic hold_request;
   logic hold_taken;
   int   hold_left;
   int   fail_count;
   int   pending;
   int   cycles = 0;
   int   sent_items = 0;
   int   send_idle_pct;
   int   recv_idle_pct;

   mlr_req_if req_ch();
   mlr_rsp_if rsp_ch();

   midpoint_line_rasterizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mlr_pixel_checker pixel_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // pixel sink: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         hold_taken   <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken   <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic int rand_coord();
      return int'($urandom_range(4095)) - 2048;
   endfunction

   function automatic int near(input int base, input int span);
      int v;
      v = base + int'($urandom_range(2 * span)) - span;
      if (v > 2047) v = 2047;
      if (v < -2048) v = -2048;
      return v;
   endfunction

   function automatic int dist_of(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic mlr_pkg::req_type make_req(input logic op, input int x1, input int y1,
                                                 input int x2, input int y2);
      mlr_pkg::req_type r;
      r.opcode   = op;
      r.first_x  = mlr_pkg::coord_type'(x1);
      r.first_y  = mlr_pkg::coord_type'(y1);
      r.second_x = mlr_pkg::coord_type'(x2);
      r.second_y = mlr_pkg::coord_type'(y2);
      return r;
   endfunction

   task automatic send_item(input mlr_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_items++;
   endtask

   // start item, then step items with don't-care coordinates
   task automatic draw_line(input int x1, input int y1, input int x2, input int y2,
                            input int steps);
      send_item(make_req(mlr_pkg::OP_START, x1, y1, x2, y2));
      repeat (steps)
         send_item(make_req(mlr_pkg::OP_STEP, rand_coord(), rand_coord(),
                            rand_coord(), rand_coord()));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_lines(input int item_goal);
      int kind;
      int x1;
      int y1;
      int x2;
      int y2;
      int len;
      int steps;
      while (sent_items < item_goal) begin
         kind = $urandom_range(15);
         x1   = rand_coord();
         y1   = rand_coord();
         if (kind < 9) begin
            x2 = near(x1, (kind < 2) ? 40 : 8);
            y2 = near(y1, (kind < 2) ? 40 : 8);
         end else if (kind < 11) begin
            if ($urandom_range(1)) begin
               x2 = x1;
               y2 = near(y1, 12);
            end else begin
               y2 = y1;
               x2 = near(x1, 12);
            end
         end else if (kind == 11) begin
            x2 = x1;
            y2 = y1;
         end else begin
            x2 = rand_coord();
            y2 = rand_coord();
         end
         len = (dist_of(x1, x2) > dist_of(y1, y2)) ? dist_of(x1, x2) : dist_of(y1, y2);
         // wide lines are cut short by the next start
         if (kind >= 12)
            steps = $urandom_range(24);
         else if ($urandom_range(7) == 0)
            steps = $urandom_range(len);
         else
            steps = len + (($urandom_range(5) == 0) ? $urandom_range(2, 1) : 0);
         draw_line(x1, y1, x2, y2, steps);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      hold_request   <= 1'b0;
      send_idle_pct  = 11;
      recv_idle_pct  <= 88;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_item(make_req(mlr_pkg::OP_STEP, 2047, -2048, 2047, -2048));
      draw_line(-2048, 2047, -2048, 2047, 1);
      draw_line(3, -7, 0, -7, 3);
      draw_line(2, 1, 2, -1, 2);
      draw_line(0, 0, 3, -2, 3);
      draw_line(0, 0, -1, 3, 3);
      draw_line(-2048, -2048, 2047, 2047, 2);
      draw_line(2047, -2048, -2048, 2047, 2);

      random_lines(540);
      drain();
      send_idle_pct = 88;
      recv_idle_pct <= 11;
      random_lines(1045);
      drain();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_request  <= 1'b1;
      random_lines(ITEM_TARGET);
      drain();
      repeat (8) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
